// ===== src/v4tr_pkg.sv =====
package v4tr_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_BYTES = 4;
  localparam int ADDR_W     = BYTE_W * ADDR_BYTES;

  typedef logic [2:0] level_t;

  localparam level_t MARK_LEVEL = 3'd4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_MATCH  = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EMIT
  } state_t;

  function automatic logic [BYTE_W-1:0] addr_byte(logic [ADDR_W-1:0] a, level_t l);
    logic [BYTE_W-1:0] b;
    unique case (l)
      3'd0:    b = a[31:24];
      3'd1:    b = a[23:16];
      3'd2:    b = a[15:8];
      3'd3:    b = a[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/v4tr_ram.sv =====
module v4tr_ram
  import v4tr_pkg::*;
#(
  parameter int NW = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [NW+BYTE_W-1:0] waddr,
  input  logic [NW-1:0]        wdata,
  input  logic [NW+BYTE_W-1:0] raddr,
  output logic [NW-1:0]        rdata
);

  localparam int AW    = NW + BYTE_W;
  localparam int DEPTH = 1 << AW;

  logic [NW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ipv4_trie_exact_match_core.sv =====
// channel | signals                          | direction
// req     | req_valid req_stall func ip_address | in  (stall driven out)
// rsp     | rsp_valid rsp_stall hit full_res   | out (stall driven in)
//
// One beat in flight at a time: the beat is accepted, walks one trie level per
// look step plus a last step for the rule mark in the child memory, then moves
// to the output register; an early lookup miss or a refused insert ends sooner.
// After reset all 256 << clog2(NODE_COUNT) entries of the child memory (65536 by
// default) are swept to zero, with req_stall high throughout.
// A stalled response waits in the output register while the next beat is taken.
module ipv4_trie_exact_match_core
  import v4tr_pkg::*;
#(
  parameter int NODE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        func,
  input  logic [31:0] ip_address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        hit,
  output logic        full_res
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int AW  = NW + BYTE_W;
  localparam int NFW = $clog2(NODE_COUNT + 1);

  state_t            state, state_next;
  level_t            lvl, lvl_next;
  logic [NW-1:0]     node, node_next;
  logic [31:0]       addr, addr_next;
  logic              func_q, func_next;
  logic [NFW-1:0]    nf, nf_next;
  logic [AW-1:0]     clr_cnt;
  logic              res_hit, res_hit_next;
  logic              res_full, res_full_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [NW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [NW-1:0]     mem_rdata;

  logic              accept;
  logic              finish;
  logic              load_rsp;
  logic [BYTE_W-1:0] cur_byte;
  logic [NW-1:0]     nxt;
  logic              advance;

  v4tr_ram #(.NW(NW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept   = (state == S_IDLE) && req_valid;
  assign cur_byte = addr_byte(addr, lvl);

  always_comb begin
    lvl_next      = lvl;
    node_next     = node;
    addr_next     = addr;
    func_next     = func_q;
    nf_next       = nf;
    res_hit_next  = res_hit;
    res_full_next = res_full;
    mem_we        = 1'b0;
    mem_waddr     = {node, cur_byte};
    mem_wdata     = '0;
    mem_raddr     = '0;
    finish        = 1'b0;
    advance       = 1'b0;
    nxt           = mem_rdata;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_IDLE: begin
        if (accept) begin
          addr_next = ip_address;
          func_next = func;
          lvl_next  = '0;
          node_next = '0;
          mem_raddr = {{NW{1'b0}}, ip_address[31:24]};
        end
      end
      S_LOOK: begin
        if (lvl == MARK_LEVEL) begin
          if (func_q == FUNC_MATCH) begin
            res_hit_next = (mem_rdata != '0);
          end else begin
            res_hit_next = 1'b0;
            mem_we       = 1'b1;
            mem_wdata    = NW'(1);
          end
          res_full_next = 1'b0;
          finish        = 1'b1;
        end else if (mem_rdata != '0) begin
          advance = 1'b1;
        end else if (func_q == FUNC_MATCH) begin
          res_hit_next  = 1'b0;
          res_full_next = 1'b0;
          finish        = 1'b1;
        end else if (nf == NFW'(NODE_COUNT)) begin
          res_hit_next  = 1'b0;
          res_full_next = 1'b1;
          finish        = 1'b1;
        end else begin
          nxt       = nf[NW-1:0];
          mem_we    = 1'b1;
          mem_wdata = nf[NW-1:0];
          nf_next   = nf + NFW'(1);
          advance   = 1'b1;
        end
        if (advance) begin
          lvl_next  = level_t'(lvl + 3'd1);
          node_next = nxt;
          mem_raddr = {nxt, addr_byte(addr, level_t'(lvl + 3'd1))};
        end
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_LOOK;
      S_LOOK:  if (finish) state_next = S_EMIT;
      S_EMIT:  if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    req_stall = (state != S_IDLE);
    load_rsp  = (state == S_EMIT) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      nf        <= NFW'(1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      nf    <= nf_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl      <= lvl_next;
    node     <= node_next;
    addr     <= addr_next;
    func_q   <= func_next;
    res_hit  <= res_hit_next;
    res_full <= res_full_next;
    if (load_rsp) begin
      hit      <= res_hit;
      full_res <= res_full;
    end
  end

  a_nf_bound: assert property (@(posedge clk) disable iff (rst)
    nf <= NFW'(NODE_COUNT))
    else $error("node allocator past pool end");

  a_rsp_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_EMIT)
    else $error("response raised outside emit");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_LOOK || state == S_CLEAR))
    else $error("memory write outside walk or sweep");

  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && full_res))
    else $error("hit and full together");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> lvl <= MARK_LEVEL)
    else $error("walk level out of range");

endmodule
